@@ sv/oal_pkg.sv @@
// Shared types and constants for the ordered array list.
// Cell command encoding, controller states, field widths and status codes.
// No dependencies.
package oal_pkg;

	// Field widths of the request and response transactions
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 10;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// Default number of list entries
	localparam int CAPACITY_DEF = 1024;

	// Operation codes on the func field; code 3 is a no-op
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	// What every cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	// Command broadcast from the controller to the row of cells
	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
	} cell_cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

@@ sv/oal_intf.sv @@
// Valid/ready channel interfaces for the ordered array list.
// Request carries func/position/value, response carries status/found_index/count.
// Depends on oal_pkg.
interface oal_req_if;
	logic                                valid;
	logic                                ready;
	logic [oal_pkg::FUNC_W-1:0]          func;
	logic [oal_pkg::POS_W-1:0]           position;
	logic signed [oal_pkg::DATA_W-1:0]   value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface oal_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [oal_pkg::STATUS_W-1:0]        status;
	logic [oal_pkg::POS_W-1:0]           found_index;
	logic [oal_pkg::COUNT_W-1:0]         count;

	modport source (output valid, output status, output found_index, output count, input ready);
	modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

@@ sv/oal_cell.sv @@
// One storage cell of the list: holds a single entry and trades it with its neighbors.
// Shifts up on insert, down on remove, and rotates toward cell 0 during a search.
// Depends on oal_pkg.
module oal_cell #(
	parameter int IDX = 0,
	parameter int XW  = 11
) (
	input  logic                              clk,
	input  oal_pkg::cell_cmd_t                cmd,
	input  logic [XW-1:0]                     lim,
	input  logic signed [oal_pkg::DATA_W-1:0] din,
	input  logic signed [oal_pkg::DATA_W-1:0] left,
	input  logic signed [oal_pkg::DATA_W-1:0] right,
	input  logic signed [oal_pkg::DATA_W-1:0] head,
	output logic signed [oal_pkg::DATA_W-1:0] q
);

	localparam logic [XW-1:0] IDX_X  = XW'(IDX);
	localparam logic [XW-1:0] NEXT_X = XW'(IDX + 1);

	logic signed [oal_pkg::DATA_W-1:0] data_q;
	logic signed [oal_pkg::DATA_W-1:0] data_d;
	logic [XW-1:0]                     pos_x;

	assign pos_x = XW'(cmd.pos);

	// Local decision from this cell's fixed index
	always_comb begin
		data_d = data_q;
		unique case (cmd.op)
			oal_pkg::CELL_INSERT: begin
				if (IDX_X > pos_x) begin
					data_d = left;
				end else if (IDX_X == pos_x) begin
					data_d = din;
				end
			end
			oal_pkg::CELL_REMOVE: begin
				if (IDX_X >= pos_x) begin
					data_d = right;
				end
			end
			oal_pkg::CELL_ROTATE: begin
				// last occupied cell wraps around to the head entry
				if (NEXT_X == lim) begin
					data_d = head;
				end else if (NEXT_X < lim) begin
					data_d = right;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign q = data_q;

endmodule

@@ sv/oal_ctrl.sv @@
// Sequencer of the ordered array list: decodes requests, keeps the entry count,
// drives the cell row, runs the rotating search and holds the response register.
// Depends on oal_pkg and the channel interfaces in oal_intf.sv.
module oal_ctrl #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
	parameter int CW       = 11,
	parameter int XW       = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	oal_req_if.sink                           req,
	oal_rsp_if.source                         rsp,
	output oal_pkg::cell_cmd_t                cmd,
	output logic [XW-1:0]                     lim,
	output logic signed [oal_pkg::DATA_W-1:0] din,
	input  logic signed [oal_pkg::DATA_W-1:0] head
);

	oal_pkg::state_t                   state_q, state_d;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     scan_q;
	logic                              hit_q;
	logic signed [oal_pkg::DATA_W-1:0] key_q;
	logic [oal_pkg::STATUS_W-1:0]      status_q;
	logic [CW-1:0]                     index_q;

	logic                              out_valid_q;
	logic [oal_pkg::STATUS_W-1:0]      out_status_q;
	logic [oal_pkg::POS_W-1:0]         out_index_q;
	logic [oal_pkg::COUNT_W-1:0]       out_count_q;

	logic                              acc;
	logic                              out_free;
	logic                              done_move;
	logic                              scan_last;
	logic                              match;
	logic [XW-1:0]                     pos_x;
	logic [XW-1:0]                     count_x;

	logic [oal_pkg::STATUS_W-1:0]      dec_status;
	oal_pkg::cell_op_t                 dec_op;
	logic [CW-1:0]                     dec_count;
	logic                              dec_scan;

	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign done_move = (state_q == oal_pkg::S_DONE) && out_free;
	assign scan_last = scan_q == (count_q - CW'(1));
	assign match     = head == key_q;
	assign pos_x     = XW'(req.position);
	assign count_x   = XW'(count_q);

	// Request decode against the current count
	always_comb begin
		dec_status = oal_pkg::ST_OK;
		dec_op     = oal_pkg::CELL_HOLD;
		dec_count  = count_q;
		dec_scan   = 1'b0;
		unique case (req.func)
			oal_pkg::FN_INSERT: begin
				if (count_q >= CW'(CAPACITY)) begin
					dec_status = oal_pkg::ST_FULL;
				end else if (pos_x > count_x) begin
					dec_status = oal_pkg::ST_BADPOS;
				end else begin
					dec_op    = oal_pkg::CELL_INSERT;
					dec_count = count_q + CW'(1);
				end
			end
			oal_pkg::FN_REMOVE: begin
				if (pos_x >= count_x) begin
					dec_status = oal_pkg::ST_BADPOS;
				end else begin
					dec_op    = oal_pkg::CELL_REMOVE;
					dec_count = count_q - CW'(1);
				end
			end
			oal_pkg::FN_FIND: begin
				if (count_q == '0) begin
					dec_status = oal_pkg::ST_NOTFOUND;
				end else begin
					dec_scan = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oal_pkg::S_IDLE: begin
				if (acc) begin
					state_d = dec_scan ? oal_pkg::S_SCAN : oal_pkg::S_DONE;
				end
			end
			oal_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = oal_pkg::S_DONE;
				end
			end
			oal_pkg::S_DONE: begin
				if (out_free) begin
					state_d = oal_pkg::S_IDLE;
				end
			end
			default: state_d = oal_pkg::S_IDLE;
		endcase
	end

	// State outputs: handshake and cell row command; ready is high in idle
	always_comb begin
		req.ready = state_q == oal_pkg::S_IDLE;
		cmd.pos   = req.position;
		cmd.op    = oal_pkg::CELL_HOLD;
		unique case (state_q)
			oal_pkg::S_IDLE: begin
				if (req.valid) begin
					cmd.op = dec_op;
				end
			end
			oal_pkg::S_SCAN: cmd.op = oal_pkg::CELL_ROTATE;
			default: ;
		endcase
	end

	assign lim = count_x;
	assign din = req.value;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oal_pkg::S_IDLE;
			count_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				count_q <= dec_count;
				hit_q   <= 1'b0;
			end else if (state_q == oal_pkg::S_SCAN && match) begin
				hit_q <= 1'b1;
			end
			if (done_move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search and response payload
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= dec_status;
			key_q    <= req.value;
			scan_q   <= '0;
			index_q  <= '0;
		end else if (state_q == oal_pkg::S_SCAN) begin
			scan_q <= scan_q + CW'(1);
			if (!hit_q && match) begin
				index_q <= scan_q;
			end
			if (scan_last) begin
				status_q <= (hit_q || match) ? oal_pkg::ST_OK : oal_pkg::ST_NOTFOUND;
			end
		end
		if (done_move) begin
			out_status_q <= status_q;
			out_index_q  <= oal_pkg::POS_W'(index_q);
			out_count_q  <= oal_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_index_q;
	assign rsp.count       = out_count_q;

endmodule

@@ sv/ordered_array_list.sv @@
// Ordered array list: top level with the sequencer and a row of CAPACITY entry cells.
// Depends on oal_pkg, oal_intf.sv, oal_cell and oal_ctrl.
//
// Usage:
//   req (sink): func 0 insert, 1 remove, 2 find, 3 no-op; position and value.
//   rsp (source): status, found_index and the entry count after the operation.
//   A transaction moves on a rising clk edge with valid and ready both high.
// Sequencing:
//   Insert and remove update the cell row at the acceptance edge; no-op and
//   refused requests leave it unchanged. The sequencer then enters the done state,
//   which registers the response, and returns to idle to take the next request.
//   Find rotates the occupied cells past cell 0, one entry per cycle, in the scan
//   state; the done state then registers the response and idle takes the next
//   request; the rotation restores the order.
//   One request is in work at a time; req.ready is high only while idle.
// Reset:
//   arst_n clears the count, the sequencer and the response valid; the list is
//   empty afterwards and entry contents need no clearing.
// Stalls:
//   A finished response waits in the output register while rsp.ready is low; a
//   further request can still be accepted, and its result is held internally
//   until the output register frees up.
module ordered_array_list #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	oal_req_if.sink   req,
	oal_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;

	oal_pkg::cell_cmd_t                cmd;
	logic [XW-1:0]                     lim;
	logic signed [oal_pkg::DATA_W-1:0] din;
	logic signed [oal_pkg::DATA_W-1:0] cell_q [CAPACITY];

	oal_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW),
		.XW       (XW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.lim    (lim),
		.din    (din),
		.head   (cell_q[0])
	);

	// Row of entry cells; the ends see their own value as the missing neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [oal_pkg::DATA_W-1:0] left_w;
		logic signed [oal_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cell_q[i];
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		oal_cell #(
			.IDX (i),
			.XW  (XW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.lim   (lim),
			.din   (din),
			.left  (left_w),
			.right (right_w),
			.head  (cell_q[0]),
			.q     (cell_q[i])
		);
	end

endmodule

@@ sv/oal_checker.sv @@
// Port-level checks for the ordered array list, bound to the top level.
// Depends on oal_pkg and ordered_array_list.
module oal_checker #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [oal_pkg::STATUS_W-1:0]  rsp_status,
	input logic [oal_pkg::POS_W-1:0]     rsp_found_index,
	input logic [oal_pkg::COUNT_W-1:0]   rsp_count
);

	// A pending response is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// One request at a time: no acceptance right after another
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in work");

	// Count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_count) <= CAPACITY)
		else $error("count above capacity");

	// A full refusal only happens at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == oal_pkg::ST_FULL
			|-> rsp_count == oal_pkg::COUNT_W'(CAPACITY))
		else $error("full status below capacity");

	// A nonzero index only comes with a successful find
	a_index_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found_index != '0 |-> rsp_status == oal_pkg::ST_OK)
		else $error("found index with failing status");

endmodule

bind ordered_array_list oal_checker #(
	.CAPACITY (CAPACITY)
) u_oal_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_index (rsp.found_index),
	.rsp_count       (rsp.count)
);

@@ tb/ordered_array_list_test.sv @@
// Self-checking testbench for ordered_array_list: drives list requests on the
// request channel and checks every response against a queue-based list tracker.
// Depends on oal_pkg, oal_intf.sv and ordered_array_list.
module ordered_array_list_test;
	timeunit 1ns;
	timeprecision 1ps;

	// func code 3 has no name in the package; the block treats it as a no-op
	localparam logic [oal_pkg::FUNC_W-1:0] FN_NOP = 2'd3;

	localparam int RANDOM_OPS  = 540;
	localparam int TAIL_OPS    = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;

	typedef logic signed [oal_pkg::DATA_W-1:0] word_t;

	typedef struct packed {
		logic [oal_pkg::STATUS_W-1:0] status;
		logic [oal_pkg::POS_W-1:0]    found_index;
		logic [oal_pkg::COUNT_W-1:0]  count;
	} list_result_t;

	// Mirror of the list contents plus the responses still owed by the block
	class list_tracker;
		word_t        contents_q[$];
		list_result_t owed_q[$];
		int           capacity;
		int           errors;

		function new(int cap);
			capacity = cap;
			errors   = 0;
		endfunction

		function int list_len();
			return contents_q.size();
		endfunction

		function word_t entry_at(int idx);
			return contents_q[idx];
		endfunction

		function bit holds(word_t v);
			foreach (contents_q[i])
				if (contents_q[i] == v)
					return 1'b1;
			return 1'b0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Apply one accepted request to the mirror and queue the response it owes
		function void note_request(logic [oal_pkg::FUNC_W-1:0] f,
				logic [oal_pkg::POS_W-1:0] p, word_t v);
			list_result_t r;
			int           i;
			r.status      = oal_pkg::ST_OK;
			r.found_index = '0;
			case (f)
				oal_pkg::FN_INSERT: begin
					if (contents_q.size() >= capacity)
						r.status = oal_pkg::ST_FULL;
					else if (int'(p) > contents_q.size())
						r.status = oal_pkg::ST_BADPOS;
					else
						contents_q.insert(int'(p), v);
				end
				oal_pkg::FN_REMOVE: begin
					if (int'(p) >= contents_q.size())
						r.status = oal_pkg::ST_BADPOS;
					else
						contents_q.delete(int'(p));
				end
				oal_pkg::FN_FIND: begin
					r.status = oal_pkg::ST_NOTFOUND;
					i = 0;
					while (i < contents_q.size() && r.status != oal_pkg::ST_OK) begin
						if (contents_q[i] == v) begin
							r.status      = oal_pkg::ST_OK;
							r.found_index = oal_pkg::POS_W'(i);
						end
						i++;
					end
				end
				default: ;
			endcase
			r.count = oal_pkg::COUNT_W'(contents_q.size());
			owed_q.push_back(r);
		endfunction

		// Compare one response transaction with the oldest owed result
		function void check_response(logic [oal_pkg::STATUS_W-1:0] st,
				logic [oal_pkg::POS_W-1:0] idx, logic [oal_pkg::COUNT_W-1:0] cnt);
			list_result_t r;
			if (owed_q.size() == 0) begin
				$error("response transaction with no request outstanding");
				errors++;
				return;
			end
			r = owed_q.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				errors++;
			end
			if (idx !== r.found_index) begin
				$error("found_index: expected %0d, actual %0d", r.found_index, idx);
				errors++;
			end
			if (cnt !== r.count) begin
				$error("count: expected %0d, actual %0d", r.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idle_on;

	list_tracker tracker;

	oal_req_if req_ch();
	oal_rsp_if rsp_ch();

	ordered_array_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin : watchdog
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Values: a quarter from a tiny range so duplicates show up
	function automatic word_t any_value();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 8) - 4;
		return $urandom;
	endfunction

	// Offer one request transaction, with an optional idle burst first
	task automatic send_request(logic [oal_pkg::FUNC_W-1:0] f,
			logic [oal_pkg::POS_W-1:0] p, word_t v);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.func     <= f;
		req_ch.position <= p;
		req_ch.value    <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		tracker.note_request(f, p, v);
	endtask

	// One random operation; insert weight follows the list length
	task automatic random_item();
		int                         n;
		int                         k;
		int                         ins_pct;
		logic [oal_pkg::POS_W-1:0]  p;
		word_t                      v;
		n       = tracker.list_len();
		ins_pct = (n < 8) ? 60 : (n > 48) ? 25 : 42;
		k       = $urandom_range(0, 99);
		p       = oal_pkg::POS_W'($urandom_range(0, 1023));
		v       = any_value();
		if (k < ins_pct) begin
			if ($urandom_range(0, 6) != 0)
				p = oal_pkg::POS_W'($urandom_range(0, n));
			send_request(oal_pkg::FN_INSERT, p, v);
		end else if (k < 72) begin
			if (n > 0 && $urandom_range(0, 6) != 0)
				p = oal_pkg::POS_W'($urandom_range(0, n - 1));
			send_request(oal_pkg::FN_REMOVE, p, v);
		end else if (k < 95) begin
			if (n > 0 && $urandom_range(0, 9) < 6)
				v = tracker.entry_at($urandom_range(0, n - 1));
			send_request(oal_pkg::FN_FIND, p, v);
		end else begin
			send_request(FN_NOP, p, v);
		end
	endtask

	// Response side: checks, random stalls and one long hold-off
	initial begin : rsp_side
		int stall_left;
		int seen;
		bit long_done;
		stall_left = 0;
		seen       = 0;
		long_done  = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				tracker.check_response(rsp_ch.status, rsp_ch.found_index, rsp_ch.count);
				seen++;
			end
			// long hold lets the block fill up and drop req.ready
			if (seen == 50 && !long_done) begin
				long_done  = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Request side and end of run
	initial begin : req_side
		word_t v;
		tracker = new(oal_pkg::CAPACITY_DEF);
		idle_on = 1'b1;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.func     <= oal_pkg::FN_INSERT;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, extremes, duplicates, bad positions, no-op
		send_request(oal_pkg::FN_FIND,   10'd0,    32'sd0);
		send_request(oal_pkg::FN_REMOVE, 10'd0,    32'sd0);
		send_request(oal_pkg::FN_INSERT, 10'd1,    32'sd7);
		send_request(oal_pkg::FN_INSERT, 10'd1023, 32'sd7);
		send_request(oal_pkg::FN_INSERT, 10'd0,    32'sh8000_0000);
		send_request(oal_pkg::FN_INSERT, 10'd1,    32'sh7fff_ffff);
		send_request(oal_pkg::FN_INSERT, 10'd1,    -32'sd1);
		send_request(oal_pkg::FN_INSERT, 10'd0,    32'sd0);
		send_request(oal_pkg::FN_INSERT, 10'd4,    32'sd5);
		send_request(oal_pkg::FN_INSERT, 10'd2,    32'sd5);
		send_request(oal_pkg::FN_FIND,   10'd0,    32'sd5);
		send_request(oal_pkg::FN_FIND,   10'd0,    32'sh8000_0000);
		send_request(oal_pkg::FN_FIND,   10'd0,    32'sh7fff_ffff);
		send_request(oal_pkg::FN_FIND,   10'd0,    32'sd0);
		send_request(oal_pkg::FN_FIND,   10'd0,    32'sd12345);
		send_request(FN_NOP,             10'd1023, -32'sd1);
		send_request(oal_pkg::FN_REMOVE, 10'd1023, 32'sd0);
		send_request(oal_pkg::FN_REMOVE, 10'd6,    32'sd0);
		send_request(oal_pkg::FN_INSERT, 10'd7,    32'sd9);
		send_request(oal_pkg::FN_REMOVE, 10'd5,    32'sd0);
		send_request(oal_pkg::FN_REMOVE, 10'd0,    32'sd0);
		send_request(oal_pkg::FN_REMOVE, 10'd1,    32'sd0);
		send_request(oal_pkg::FN_FIND,   10'd1023, -32'sd1);

		// Random mix; idling switches on and off in stretches of 60, none in the tail
		for (int i = 0; i < RANDOM_OPS; i++) begin
			idle_on = (i < RANDOM_OPS - TAIL_OPS) && (((i / 60) % 2) == 0);
			random_item();
		end

		// Last part, no idling: both ends of the list, a missing value, edge positions
		idle_on = 1'b0;
		if (tracker.list_len() > 0) begin
			send_request(oal_pkg::FN_FIND, 10'd0, tracker.entry_at(tracker.list_len() - 1));
			send_request(oal_pkg::FN_FIND, 10'd0, tracker.entry_at(0));
		end
		do v = $urandom; while (tracker.holds(v));
		send_request(oal_pkg::FN_FIND,   10'd0,    v);
		send_request(oal_pkg::FN_REMOVE, 10'd1023, 32'sd0);
		send_request(oal_pkg::FN_INSERT, 10'd1023, $urandom);
		send_request(oal_pkg::FN_REMOVE, 10'd0,    32'sd0);
		send_request(FN_NOP,             10'd0,    32'sd0);
		req_ch.valid <= 1'b0;

		// Drain, then allow one full find time for anything unexpected
		while (tracker.pending() > 0) @(posedge clk);
		repeat (oal_pkg::CAPACITY_DEF + 4) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
